// ===== hdl/llcta_pkg.sv =====
// Package: shared types and codes for the least-loaded class task arbiter.
package llcta_pkg;

    localparam int OP_W     = 2;
    localparam int CLASS_W  = 3;
    localparam int TAGF_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GRANT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOWORK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NORUN  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CLASS_W-1:0] class_id;
        logic [TAGF_W-1:0]  task_tag;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  grant_class;
        logic [TAGF_W-1:0]   grant_tag;
    } rsp_t;

endpackage

// ===== hdl/llcta_tag_ram.sv =====
// Tag storage: one memory holding every class FIFO, registered read.
module llcta_tag_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/least_loaded_class_task_arbiter_unit.sv =====
// Top level: least-loaded class task arbiter with per-class FIFOs.
//
// One beat in, one beat out. Push, unused operations and a dequeue on an empty
// list go from S_EXEC straight to S_OUT; a dequeue walks the class list one
// entry per cycle through a single compare unit in S_SCAN, then passes S_PICK
// and, when a task is granted, S_READ before S_OUT; a finish that retires its
// class searches and shifts the list one entry per cycle in S_SHIFT. The block
// takes no new beat until the result has moved into the output register; a
// result waiting there for the receiver does not hold off the next beat. All
// class FIFOs share one tag memory of 2**(CW+QW) entries (NUM_CLASSES *
// QUEUE_DEPTH when both are powers of two) with a registered read port; FIFO
// fill and head pointers reset to zero, so no clearing pass is needed.
module least_loaded_class_task_arbiter_unit
    import llcta_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_RUNNERS = 16,
    parameter int TAG_WIDTH   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LW  = $clog2(NUM_CLASSES + 1);
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RW  = $clog2(MAX_RUNNERS + 1);
    localparam int AW  = CW + QW;
    localparam int TW  = (TAG_WIDTH < TAGF_W) ? TAG_WIDTH : TAGF_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;

    req_t             req_reg;
    logic [CW-1:0]    order_reg [NUM_CLASSES];
    logic [LW-1:0]    len_reg;
    logic [CW-1:0]    pos_reg;
    logic [NUM_CLASSES-1:0] present_reg;
    logic [RW-1:0]    runners_reg [NUM_CLASSES];
    logic [QW-1:0]    head_reg [NUM_CLASSES];
    logic [FW-1:0]    fill_reg [NUM_CLASSES];

    logic [CW-1:0]    start_reg;
    logic [LW-1:0]    step_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    best_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CW-1:0]    gclass_reg;
    logic [TW-1:0]    gtag_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [TW-1:0]    rd_data;

    // Class field sized to index width; out-of-range ids are dropped.
    logic [CW-1:0] cid;
    logic          cid_ok;
    assign cid    = CW'(req_reg.class_id);
    assign cid_ok = ({{32-CLASS_W{1'b0}}, req_reg.class_id} < NUM_CLASSES);

    logic [CW-1:0] cur_cls;
    assign cur_cls = order_reg[idx_reg];

    // Tail slot wraps at the queue depth.
    logic [FW:0]   tail_sum;
    logic [QW-1:0] tail_slot;
    assign tail_sum  = (FW+1)'(head_reg[cid]) + (FW+1)'(fill_reg[cid]);
    assign tail_slot = (tail_sum >= (FW+1)'(QUEUE_DEPTH))
                       ? QW'(tail_sum - (FW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);

    assign wr_en   = (state_reg == S_EXEC) && (req_reg.operation == OP_PUSH) && cid_ok
                     && (!present_reg[cid] || fill_reg[cid] != FW'(QUEUE_DEPTH));
    assign wr_addr = {cid, present_reg[cid] ? tail_slot : QW'(0)};
    assign rd_addr = {best_reg, head_reg[best_reg]};

    llcta_tag_ram #(.ADDR_W(AW), .DATA_W(TW)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req_reg.task_tag[TW-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            pos_reg     <= '0;
            present_reg <= '0;
            m_valid     <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                runners_reg[i] <= '0;
                head_reg[i]    <= '0;
                fill_reg[i]    <= '0;
            end
        end else begin
            // Drop the result beat once taken, unless a new one loads now.
            if (m_valid && m_ready && state_reg != S_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg    <= s_data;
                        status_reg <= ST_DONE;
                        gclass_reg <= '0;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_OUT;
                    if (req_reg.operation == OP_PUSH && cid_ok) begin
                        // Join the list on first sight, then append the tag.
                        if (!present_reg[cid]) begin
                            present_reg[cid] <= 1'b1;
                            head_reg[cid]    <= '0;
                            fill_reg[cid]    <= FW'(1);
                            if (len_reg < LW'(NUM_CLASSES)) begin
                                order_reg[len_reg[CW-1:0]] <= cid;
                                len_reg <= len_reg + 1'b1;
                            end
                        end else if (fill_reg[cid] == FW'(QUEUE_DEPTH)) begin
                            status_reg <= ST_FULL;
                        end else begin
                            fill_reg[cid] <= fill_reg[cid] + 1'b1;
                        end
                    end else if (req_reg.operation == OP_DEQUEUE) begin
                        if (len_reg == '0) begin
                            status_reg <= ST_NOWORK;
                        end else begin
                            // Start the scan at the rotating position.
                            logic [CW-1:0] st;
                            st = (LW'(pos_reg) < len_reg) ? pos_reg : '0;
                            start_reg <= st;
                            idx_reg   <= st;
                            best_reg  <= order_reg[st];
                            step_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                    end else if (req_reg.operation == OP_FINISH && cid_ok) begin
                        logic [RW-1:0] rn;
                        rn = runners_reg[cid];
                        if (rn == '0) begin
                            status_reg <= ST_NORUN;
                        end else begin
                            rn = rn - 1'b1;
                            runners_reg[cid] <= rn;
                        end
                        if (present_reg[cid] && rn == '0 && fill_reg[cid] == '0) begin
                            present_reg[cid] <= 1'b0;
                            head_reg[cid]    <= '0;
                            idx_reg          <= '0;
                            step_reg         <= '0;
                            state_reg        <= S_SHIFT;
                        end
                    end
                end
                S_SCAN: begin
                    // Compare one list entry per cycle; keep strict minimum.
                    if (runners_reg[cur_cls] < runners_reg[best_reg]) begin
                        best_reg <= cur_cls;
                    end
                    idx_reg  <= (LW'(idx_reg) + 1'b1 >= len_reg) ? '0 : idx_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg + 1'b1 >= len_reg) begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK: begin
                    pos_reg <= (LW'(start_reg) + 1'b1 >= len_reg) ? '0 : start_reg + 1'b1;
                    if (fill_reg[best_reg] == '0
                        || runners_reg[best_reg] >= RW'(MAX_RUNNERS)) begin
                        status_reg <= ST_NOWORK;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // Memory read issued in S_PICK lands now; hold it and pop the head.
                    gtag_reg <= rd_data;
                    head_reg[best_reg] <= (head_reg[best_reg] == QW'(QUEUE_DEPTH - 1))
                                          ? '0 : head_reg[best_reg] + 1'b1;
                    fill_reg[best_reg]    <= fill_reg[best_reg] - 1'b1;
                    runners_reg[best_reg] <= runners_reg[best_reg] + 1'b1;
                    status_reg <= ST_GRANT;
                    gclass_reg <= best_reg;
                    state_reg  <= S_OUT;
                end
                S_SHIFT: begin
                    // Find the class, then move later entries down one a cycle.
                    if (LW'(idx_reg) >= len_reg) begin
                        if (LW'(pos_reg) >= len_reg) begin
                            pos_reg <= '0;
                        end
                        state_reg <= S_OUT;
                    end else if (step_reg == '0) begin
                        if (order_reg[idx_reg] == cid) begin
                            step_reg <= LW'(1);
                            if (LW'(idx_reg) + 1'b1 >= len_reg) begin
                                len_reg <= len_reg - 1'b1;
                                if (LW'(pos_reg) >= len_reg - 1'b1) pos_reg <= '0;
                                state_reg <= S_OUT;
                            end
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else begin
                        order_reg[idx_reg] <= order_reg[CW'(LW'(idx_reg) + 1'b1)];
                        idx_reg <= idx_reg + 1'b1;
                        if (LW'(idx_reg) + 2 >= len_reg) begin
                            len_reg <= len_reg - 1'b1;
                            if (LW'(pos_reg) >= len_reg - 1'b1) pos_reg <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    // Hold the result until the output register is free.
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_data.status      <= status_reg;
                        m_data.grant_class <= CLASS_W'(gclass_reg);
                        m_data.grant_tag   <= (status_reg == ST_GRANT) ? TAGF_W'(gtag_reg) : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_least_loaded_class_task_arbiter_unit.sv =====
// Testbench: least-loaded class task arbiter, checked beat by beat against a scoreboard.
module tb_least_loaded_class_task_arbiter_unit;
    import llcta_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS      = 8;
    localparam int QDEPTH    = 16;
    localparam int MAXRUN    = 16;
    localparam int CYC_LIMIT = 600000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    least_loaded_class_task_arbiter_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Arbiter shadow state, kept in step with every accepted request beat.
    logic [2:0]  lst_order [NCLS];
    int          lst_len;
    int          scan_pos;
    bit          cls_active [NCLS];
    int          running [NCLS];
    logic [15:0] tag_fifo [NCLS][QDEPTH];
    int          fifo_head [NCLS];
    int          fifo_fill [NCLS];

    rsp_t pending_rsp [$];
    int   err_cnt;
    int   cyc_cnt;
    int   send_idle_pct;
    int   recv_stall_pct;

    function automatic void retire_if_idle(int c);
        int p;
        if (!cls_active[c] || running[c] != 0 || fifo_fill[c] != 0) return;
        for (p = 0; p < lst_len; p++) begin
            if (lst_order[p] == c) begin
                for (int q = p; q + 1 < lst_len; q++) lst_order[q] = lst_order[q + 1];
                lst_len--;
                break;
            end
        end
        cls_active[c] = 1'b0;
        fifo_head[c] = 0;
        if (scan_pos >= lst_len) scan_pos = 0;
    endfunction

    // Advance the shadow state by one request and return the expected response.
    function automatic rsp_t arbitrate(req_t rq);
        rsp_t r;
        int c;
        int start;
        int best;
        int cur;
        r = '0;
        r.status = ST_DONE;
        c = rq.class_id;
        if (rq.operation == OP_PUSH) begin
            if (!cls_active[c]) begin
                cls_active[c] = 1'b1;
                fifo_head[c] = 0;
                fifo_fill[c] = 0;
                if (lst_len < NCLS) begin
                    lst_order[lst_len] = 3'(c);
                    lst_len++;
                end
            end
            if (fifo_fill[c] >= QDEPTH) r.status = ST_FULL;
            else begin
                tag_fifo[c][(fifo_head[c] + fifo_fill[c]) % QDEPTH] = rq.task_tag;
                fifo_fill[c]++;
            end
        end else if (rq.operation == OP_DEQUEUE) begin
            if (lst_len == 0) r.status = ST_NOWORK;
            else begin
                start = (scan_pos < lst_len) ? scan_pos : 0;
                best = lst_order[start];
                for (int k = 0; k < lst_len; k++) begin
                    cur = lst_order[(start + k) % lst_len];
                    if (running[cur] < running[best]) best = cur;
                end
                scan_pos = start + 1;
                if (scan_pos >= lst_len) scan_pos = 0;
                if (fifo_fill[best] == 0 || running[best] >= MAXRUN) r.status = ST_NOWORK;
                else begin
                    r.grant_tag = tag_fifo[best][fifo_head[best]];
                    fifo_head[best] = (fifo_head[best] + 1) % QDEPTH;
                    fifo_fill[best]--;
                    running[best]++;
                    r.status = ST_GRANT;
                    r.grant_class = best[2:0];
                end
            end
        end else if (rq.operation == OP_FINISH) begin
            if (running[c] == 0) r.status = ST_NORUN;
            else running[c]--;
            retire_if_idle(c);
        end
        return r;
    endfunction

    // Directed rows: expected response typed in only where obvious; chk marks it.
    typedef struct {
        req_t rq;
        bit   chk;
        rsp_t rs;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic dir_row_t row(logic [1:0] op, int c, int t, bit chk,
                                     logic [2:0] st, int gc, int gt);
        dir_row_t d;
        d.rq = '{operation: op, class_id: c[2:0], task_tag: t[15:0]};
        d.chk = chk;
        d.rs = '{status: st, grant_class: gc[2:0], grant_tag: gt[15:0]};
        return d;
    endfunction

    // Drive one request beat; hold valid and payload until accepted.
    task automatic send_beat(req_t rq);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= rq;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.insert(pending_rsp.size(), arbitrate(rq));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge aclk);
    endtask

    // Mostly well-formed traffic: pushes and dequeues, finishes aimed at running classes.
    function automatic req_t rand_req();
        req_t rq;
        int pick;
        int c;
        rq.task_tag = 16'($urandom);
        rq.class_id = 3'($urandom_range(NCLS - 1));
        pick = $urandom_range(99);
        if (pick < 38) rq.operation = OP_PUSH;
        else if (pick < 72) rq.operation = OP_DEQUEUE;
        else if (pick < 96) begin
            rq.operation = OP_FINISH;
            c = $urandom_range(NCLS - 1);
            for (int k = 0; k < NCLS; k++)
                if (running[(c + k) % NCLS] != 0 && $urandom_range(3) != 0) begin
                    rq.class_id = 3'((c + k) % NCLS);
                    break;
                end
        end else rq.operation = OP_UNUSED;
        return rq;
    endfunction

    // Compare each response beat against the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected response %p", m_data);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status || m_data.grant_class !== want.grant_class
                    || m_data.grant_tag !== want.grant_tag) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("mismatch: expected %p actual %p", want, m_data);
                end
            end
        end
    end

    // Receiver stall: reroll ready every falling edge.
    always @(negedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int phase_pct [4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{26, 26}};
        req_t rq;
        err_cnt = 0;
        cyc_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        lst_len = 0;
        scan_pos = 0;
        for (int i = 0; i < NCLS; i++) begin
            lst_order[i] = '0;
            cls_active[i] = 1'b0;
            running[i] = 0;
            fifo_head[i] = 0;
            fifo_fill[i] = 0;
        end
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list, finish with no runner, extreme tags, full queue.
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 1, ST_NOWORK, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_FINISH, 7, 0, 1, ST_NORUN, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_UNUSED, 5, 16'hffff, 1, ST_DONE, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_PUSH, 7, 16'hffff, 1, ST_DONE, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 1, ST_GRANT, 7, 16'hffff));
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 1, ST_NOWORK, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_FINISH, 7, 0, 1, ST_DONE, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_PUSH, 0, 16'h0000, 1, ST_DONE, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_PUSH, 3, 16'h5aa5, 0, '0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 1, ST_GRANT, 0, 16'h0000));
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 0, '0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 0, '0, 0, 0));
        for (int i = 0; i < QDEPTH; i++)
            dir_rows.insert(dir_rows.size(), row(OP_PUSH, 5, 16'ha000 + i, 0, '0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_PUSH, 5, 16'h1234, 1, ST_FULL, 0, 0));
        for (int i = 0; i < QDEPTH + 2; i++)
            dir_rows.insert(dir_rows.size(), row(OP_DEQUEUE, 0, 0, 0, '0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_FINISH, 0, 0, 0, '0, 0, 0));
        dir_rows.insert(dir_rows.size(), row(OP_FINISH, 3, 0, 0, '0, 0, 0));
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].rq);
            if (dir_rows[i].chk && pending_rsp[$] != dir_rows[i].rs) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("row %0d: table says %p, predictor %p", i,
                             dir_rows[i].rs, pending_rsp[$]);
            end
        end
        // Pause the sender until every response is back.
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < 355; n++) begin
                rq = rand_req();
                send_beat(rq);
            end
            drain();
        end
        repeat (NCLS + 8) @(negedge aclk);

        if (err_cnt == 0 && pending_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
